[rtl/pptsch_pkg.sv]
// Package for the priority process table scheduler.
// Holds command and status codes, slot states and the structs shared by the
// top level and the slot cells. No dependencies.
package pptsch_pkg;

   localparam int CMD_W   = 3;
   localparam int CHAN_W  = 64;
   localparam int TID_W   = 31;
   localparam int PRIO_W  = 8;
   localparam int COUNT_W = 7;
   localparam int SLOT_W  = 6;
   localparam int STAT_W  = 2;

   localparam logic [TID_W-1:0]   PID_MAX     = {TID_W{1'b1}};
   localparam logic [TID_W-1:0]   PID_FIRST   = TID_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [PRIO_W-1:0]  PRIO_RESET  = PRIO_W'(10);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SLEEP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WAKEUP   = 3'd4;

   // Response status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NONE     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_RUN  = 2'd3;

   typedef enum logic [1:0] {
      SLOT_UNUSED   = 2'd0,
      SLOT_RUNNABLE = 2'd1,
      SLOT_RUNNING  = 2'd2,
      SLOT_SLEEPING = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      SCH_IDLE  = 2'd0,
      SCH_SWEEP = 2'd1,
      SCH_DONE  = 2'd2
   } sched_state_type;

   // Token that walks the cell chain, one cell per cycle
   typedef struct packed {
      logic               valid;
      logic               found;
      logic [PRIO_W-1:0]  prio;
      logic [TID_W-1:0]   tid;
      logic [COUNT_W-1:0] count;
   } sweep_type;

   // Update broadcast to the cell selected by the commit index
   typedef struct packed {
      logic               en;
      logic               set_state;
      slot_state_type     state;
      logic               write_task;
      logic [TID_W-1:0]   tid;
      logic [PRIO_W-1:0]  prio;
      logic               write_chan;
   } commit_type;

endpackage

[rtl/pptsch_cell.sv]
// One task slot of the scheduler table plus its stage of the sweep chain.
// Depends on pptsch_pkg.
module pptsch_cell #(
   parameter int IDXW  = 6,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pptsch_pkg::sweep_type        sweep_i,
   input  logic [IDXW-1:0]              sweep_idx_i,
   input  logic [pptsch_pkg::CMD_W-1:0] cmd_i,
   input  logic [pptsch_pkg::CHAN_W-1:0] chan_i,
   input  pptsch_pkg::commit_type       commit_i,
   input  logic [IDXW-1:0]              commit_idx_i,
   output pptsch_pkg::sweep_type        sweep_o,
   output logic [IDXW-1:0]              sweep_idx_o
);
   import pptsch_pkg::*;

   localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);

   slot_state_type    state_ff, state_in;
   logic [TID_W-1:0]  tid_ff, tid_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   sweep_type         sweep_ff, sweep_in;
   logic [IDXW-1:0]   sweep_idx_ff, sweep_idx_in;

   // Fold this slot into the passing token, then apply any commit
   always_comb begin
      sweep_in     = sweep_i;
      sweep_idx_in = sweep_idx_i;
      state_in     = state_ff;
      tid_in       = tid_ff;
      prio_in      = prio_ff;
      chan_in      = chan_ff;
      if (sweep_i.valid) begin
         case (cmd_i)
            CMD_CREATE: begin
               if (!sweep_i.found && state_ff == SLOT_UNUSED) begin
                  sweep_in.found = 1'b1;
                  sweep_idx_in   = MY_IDX;
               end
            end
            CMD_SCHEDULE: begin
               if (state_ff == SLOT_RUNNABLE &&
                   (!sweep_i.found || prio_ff > sweep_i.prio)) begin
                  sweep_in.found = 1'b1;
                  sweep_in.prio  = prio_ff;
                  sweep_in.tid   = tid_ff;
                  sweep_idx_in   = MY_IDX;
               end
            end
            CMD_WAKEUP: begin
               if (state_ff == SLOT_SLEEPING && chan_ff == chan_i) begin
                  state_in = SLOT_RUNNABLE;
                  if (sweep_i.count != COUNT_MAX) begin
                     sweep_in.count = sweep_i.count + COUNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (commit_i.en && commit_idx_i == MY_IDX) begin
         if (commit_i.set_state) begin
            state_in = commit_i.state;
         end
         if (commit_i.write_task) begin
            tid_in  = commit_i.tid;
            prio_in = commit_i.prio;
         end
         if (commit_i.write_chan) begin
            chan_in = chan_i;
         end
      end
   end

   // Slot state and sweep token; only the state and the token valid bit take reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SLOT_UNUSED;
         sweep_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      tid_ff       <= tid_in;
      prio_ff      <= prio_in;
      chan_ff      <= chan_in;
      sweep_idx_ff <= sweep_idx_in;
   end

   assign sweep_o     = sweep_ff;
   assign sweep_idx_o = sweep_idx_ff;

endmodule

[rtl/priority_process_table_scheduler.sv]
// Top level of the priority process table scheduler: control, response
// register and the chain of slot cells. Depends on pptsch_pkg, pptsch_cell.
//
// Usage:
//  - req_* channel (valid/ready) takes one command: create, schedule, yield,
//    sleep or wakeup, with a wait channel tag for sleep and wakeup.
//  - rsp_* channel (valid/ready) returns exactly one result per command.
//  - csr_write_enable/csr_write_data set the priority of new tasks; write
//    only while the block is idle.
//  - Every command sends a token down the chain of NUM_SLOTS cells, one cell
//    per cycle; each cell folds its slot into the free-slot search, the
//    priority select or the wakeup count. The DONE state then commits the
//    update and loads the response register.
//  - One command is in flight at a time: a new request is taken only once
//    the previous command has committed and the block is idle again.
//  - A finished response waits in the output register; a new request is
//    taken meanwhile, and its commit waits while the receiver stalls.
//  - Reset marks all slots unused, nothing running, next pid 1 and default
//    priority 10. No clearing pass is needed.
module priority_process_table_scheduler #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pptsch_pkg::CMD_W-1:0]    req_cmd,
   input  logic [pptsch_pkg::CHAN_W-1:0]   req_wait_channel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pptsch_pkg::STAT_W-1:0]   rsp_status,
   output logic [pptsch_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [pptsch_pkg::TID_W-1:0]    rsp_task_id,
   output logic [pptsch_pkg::TID_W-1:0]    rsp_parent_id,
   output logic [pptsch_pkg::COUNT_W-1:0]  rsp_woken_count,
   input  logic                            csr_write_enable,
   input  logic [pptsch_pkg::PRIO_W-1:0]   csr_write_data
);
   import pptsch_pkg::*;

   localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   sched_state_type   state_ff, state_in;
   logic              launch_ff, launch_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAN_W-1:0] chan_ff;
   sweep_type         best_ff;
   logic [IDXW-1:0]   best_idx_ff;
   logic [PRIO_W-1:0] default_prio_ff;
   logic              running_valid_ff, running_valid_in;
   logic [IDXW-1:0]   running_slot_ff, running_slot_in;
   logic [TID_W-1:0]  running_tid_ff, running_tid_in;
   logic [TID_W-1:0]  next_tid_ff, next_tid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, slot_in;
   logic [TID_W-1:0]   rsp_tid_ff, tid_in;
   logic [TID_W-1:0]   rsp_parent_ff, parent_in;
   logic [COUNT_W-1:0] rsp_count_ff, count_in;

   logic       req_fire, done_fire, sweep_end;
   commit_type commit;
   logic [IDXW-1:0] commit_idx;

   sweep_type       chain    [NUM_SLOTS+1];
   logic [IDXW-1:0] chain_idx[NUM_SLOTS+1];

   // Cell chain, fed by the launch token
   assign chain[0] = '{valid: launch_ff, found: 1'b0, prio: '0, tid: '0, count: '0};
   assign chain_idx[0] = '0;

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      pptsch_cell #(
         .IDXW (IDXW),
         .INDEX(g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .sweep_i     (chain[g]),
         .sweep_idx_i (chain_idx[g]),
         .cmd_i       (cmd_ff),
         .chan_i      (chan_ff),
         .commit_i    (commit),
         .commit_idx_i(commit_idx),
         .sweep_o     (chain[g+1]),
         .sweep_idx_o (chain_idx[g+1])
      );
   end

   assign sweep_end = chain[NUM_SLOTS].valid;
   assign req_fire  = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SCH_IDLE:  if (req_fire) state_in = SCH_SWEEP;
         SCH_SWEEP: if (sweep_end) state_in = SCH_DONE;
         SCH_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = SCH_IDLE;
         default:   state_in = SCH_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      done_fire = 1'b0;
      case (state_ff)
         SCH_IDLE:  req_ready = 1'b1;
         SCH_DONE:  done_fire = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign launch_in = req_fire;

   // Decide the result and the slot update at the end of the sweep
   always_comb begin
      status_in        = STAT_OK;
      slot_in          = '0;
      tid_in           = '0;
      parent_in        = '0;
      count_in         = '0;
      commit           = '0;
      commit_idx       = best_idx_ff;
      running_valid_in = running_valid_ff;
      running_slot_in  = running_slot_ff;
      running_tid_in   = running_tid_ff;
      next_tid_in      = next_tid_ff;
      case (cmd_ff)
         CMD_CREATE: begin
            if (best_ff.found) begin
               commit.en         = 1'b1;
               commit.set_state  = 1'b1;
               commit.state      = SLOT_RUNNABLE;
               commit.write_task = 1'b1;
               commit.tid        = next_tid_ff;
               commit.prio       = default_prio_ff;
               slot_in   = SLOT_W'(best_idx_ff);
               tid_in    = next_tid_ff;
               parent_in = running_valid_ff ? running_tid_ff : '0;
               next_tid_in = (next_tid_ff == PID_MAX) ? PID_FIRST
                                                      : next_tid_ff + TID_W'(1);
            end else begin
               status_in = STAT_FULL;
            end
         end
         CMD_SCHEDULE: begin
            if (running_valid_ff) begin
               status_in = STAT_BAD_RUN;
            end else if (!best_ff.found) begin
               status_in = STAT_NONE;
            end else begin
               commit.en        = 1'b1;
               commit.set_state = 1'b1;
               commit.state     = SLOT_RUNNING;
               running_valid_in = 1'b1;
               running_slot_in  = best_idx_ff;
               running_tid_in   = best_ff.tid;
               slot_in          = SLOT_W'(best_idx_ff);
               tid_in           = best_ff.tid;
            end
         end
         CMD_YIELD, CMD_SLEEP: begin
            if (!running_valid_ff) begin
               status_in = STAT_BAD_RUN;
            end else begin
               commit_idx       = running_slot_ff;
               commit.en        = 1'b1;
               commit.set_state = 1'b1;
               commit.state     = (cmd_ff == CMD_SLEEP) ? SLOT_SLEEPING : SLOT_RUNNABLE;
               commit.write_chan = (cmd_ff == CMD_SLEEP);
               running_valid_in = 1'b0;
               slot_in          = SLOT_W'(running_slot_ff);
               tid_in           = running_tid_ff;
            end
         end
         CMD_WAKEUP: begin
            count_in = best_ff.count;
         end
         default: begin
         end
      endcase
      if (!done_fire) begin
         commit.en        = 1'b0;
         running_valid_in = running_valid_ff;
         running_slot_in  = running_slot_ff;
         running_tid_in   = running_tid_ff;
         next_tid_in      = next_tid_ff;
      end
   end

   // Response valid: load on commit, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= SCH_IDLE;
         launch_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         default_prio_ff  <= PRIO_RESET;
         running_valid_ff <= 1'b0;
         running_slot_ff  <= '0;
         next_tid_ff      <= PID_FIRST;
      end else begin
         state_ff         <= state_in;
         launch_ff        <= launch_in;
         rsp_valid_ff     <= rsp_valid_in;
         running_valid_ff <= running_valid_in;
         running_slot_ff  <= running_slot_in;
         next_tid_ff      <= next_tid_in;
         if (csr_write_enable) begin
            default_prio_ff <= csr_write_data;
         end
      end
   end

   // Payload: hold command, sweep result and response
   always_ff @(posedge clock) begin
      running_tid_ff <= running_tid_in;
      if (req_fire) begin
         cmd_ff  <= req_cmd;
         chan_ff <= req_wait_channel;
      end
      if (state_ff == SCH_SWEEP && sweep_end) begin
         best_ff     <= chain[NUM_SLOTS];
         best_idx_ff <= chain_idx[NUM_SLOTS];
      end
      if (done_fire) begin
         rsp_status_ff <= status_in;
         rsp_slot_ff   <= slot_in;
         rsp_tid_ff    <= tid_in;
         rsp_parent_ff <= parent_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_task_id     = rsp_tid_ff;
   assign rsp_parent_id   = rsp_parent_ff;
   assign rsp_woken_count = rsp_count_ff;

   // A transfer in always starts a sweep
   a_req_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == SCH_SWEEP && launch_ff)
      else $error("request transfer did not start a sweep");

   // The sweep token leaving the chain always moves control to commit
   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCH_SWEEP && sweep_end) |=> state_ff == SCH_DONE)
      else $error("sweep end not followed by commit");

   // Error responses carry no task
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |->
         rsp_tid_ff == '0 && rsp_parent_ff == '0 && rsp_slot_ff == '0)
      else $error("error response carries task fields");

endmodule
